[rtl/adaptive_frame_pacer_defines.svh]
// Assertion macros for the adaptive frame pacer checker.
// No dependencies; included by files that carry assertions.
`ifndef ADAPTIVE_FRAME_PACER_DEFINES_SVH
`define ADAPTIVE_FRAME_PACER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define AFP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afp assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define AFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("afp assertion failed");

`endif

[rtl/afp_pkg.sv]
// Shared constants, register indexes and types for the adaptive frame pacer.
// No dependencies.
package afp_pkg;

  localparam int FPS_W      = 8;
  localparam int BUSY_W     = 20;
  localparam int TIME_IN_W  = 32;
  localparam int LOOP_W     = 20;
  localparam int CNT_W      = 8;
  localparam int WAIT_OUT_W = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam int MAX_WAIT_DEF  = 15;
  localparam int TIME_BITS_DEF = 32;

  // elapsed time clamp: 2^24 ms
  localparam int ECL_W  = 25;
  localparam int PROD_W = ECL_W + FPS_W;
  localparam int MS_W   = 18;
  localparam int MS_PER_S = 1000;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_FPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUSY_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUSY_LOW   = 2'd2;

  localparam logic [FPS_W-1:0]  FPS_RST       = 8'd60;
  localparam logic [BUSY_W-1:0] BUSY_HIGH_RST = 20'd1000;
  localparam logic [BUSY_W-1:0] BUSY_LOW_RST  = 20'd100;

  typedef struct packed {
    logic [FPS_W-1:0]  target_fps;
    logic [BUSY_W-1:0] busy_high;
    logic [BUSY_W-1:0] busy_low;
  } afp_cfg_t;

  typedef struct packed {
    logic                  draw_now;
    logic [WAIT_OUT_W-1:0] wait_ms;
    logic [LOOP_W-1:0]     report_loop_peak;
    logic [CNT_W-1:0]      report_fps;
    logic [CNT_W-1:0]      report_frame;
    logic [CNT_W-1:0]      report_skips;
    logic [WAIT_OUT_W-1:0] report_wait;
  } afp_res_t;

endpackage

[rtl/afp_cfg.sv]
// Configuration register file for the adaptive frame pacer.
// Depends on afp_pkg.
module afp_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [afp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afp_pkg::CFG_DATA_W-1:0] cfg_data,
  output afp_pkg::afp_cfg_t              cfg
);

  afp_pkg::afp_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_fps <= afp_pkg::FPS_RST;
      cfg_r.busy_high  <= afp_pkg::BUSY_HIGH_RST;
      cfg_r.busy_low   <= afp_pkg::BUSY_LOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        afp_pkg::REG_TARGET_FPS: cfg_r.target_fps <= afp_pkg::FPS_W'(cfg_data);
        afp_pkg::REG_BUSY_HIGH:  cfg_r.busy_high  <= afp_pkg::BUSY_W'(cfg_data);
        afp_pkg::REG_BUSY_LOW:   cfg_r.busy_low   <= afp_pkg::BUSY_W'(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

[rtl/afp_core.sv]
// Pacing state and the single-pass decision logic of the adaptive frame pacer.
// Depends on afp_pkg.
module afp_core #(
  parameter int MAX_WAIT  = afp_pkg::MAX_WAIT_DEF,
  parameter int TIME_BITS = afp_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [afp_pkg::TIME_IN_W-1:0] now_ms,
  input  afp_pkg::afp_cfg_t             cfg,
  output afp_pkg::afp_res_t             res
);

  localparam int WAIT_W = $clog2(MAX_WAIT + 1);
  localparam int EW     = (TIME_BITS > afp_pkg::ECL_W) ? TIME_BITS : afp_pkg::ECL_W;
  localparam logic [afp_pkg::ECL_W-1:0]  E_CLAMP  = afp_pkg::ECL_W'(1) << 24;
  localparam logic [afp_pkg::LOOP_W-1:0] LOOP_SAT = '1;
  localparam logic [afp_pkg::CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [WAIT_W-1:0]          WAIT_MAX = WAIT_W'(MAX_WAIT);
  localparam logic [WAIT_W-1:0]          WAIT_ONE = WAIT_W'(1);
  localparam logic [afp_pkg::MS_W-1:0]   MS_K     = afp_pkg::MS_W'(afp_pkg::MS_PER_S);

  logic [afp_pkg::LOOP_W-1:0] loop_r, loop_nxt, loop_inc;
  logic [afp_pkg::CNT_W-1:0]  frame_r, frame_nxt, frame_inc;
  logic [afp_pkg::CNT_W-1:0]  skip_r, skip_nxt;
  logic [WAIT_W-1:0]          wait_r, wait_nxt, wait_s, wait_h;
  logic [TIME_BITS-1:0]       wstart_r, wstart_nxt, now_tb, elapsed;
  logic [afp_pkg::LOOP_W-1:0] peak_r, peak_nxt;
  logic [afp_pkg::CNT_W-1:0]  flast_r, flast_nxt, slast_r, slast_nxt;
  afp_pkg::afp_res_t          shown_r, shown_nxt;

  logic [EW-1:0]                 e_ext;
  logic [afp_pkg::ECL_W-1:0]     e_cl;
  logic [afp_pkg::PROD_W-1:0]    ef;
  logic [afp_pkg::MS_W-1:0]      thr_old, thr_new, fps_ms;
  logic [afp_pkg::CNT_W-1:0]     fps_rep;
  logic                          hit, draw, skip, close;

  always_comb begin
    now_tb  = TIME_BITS'(now_ms);
    elapsed = now_tb - wstart_r;
    e_ext   = EW'(elapsed);
    e_cl    = (e_ext > EW'(E_CLAMP)) ? E_CLAMP : e_ext[afp_pkg::ECL_W-1:0];
    ef      = afp_pkg::PROD_W'(e_cl) * afp_pkg::PROD_W'(cfg.target_fps);

    loop_inc  = (loop_r == LOOP_SAT) ? loop_r : loop_r + 1'b1;
    frame_inc = (frame_r == CNT_MAX) ? frame_r : frame_r + 1'b1;
    thr_old   = afp_pkg::MS_W'(frame_r) * MS_K;
    thr_new   = afp_pkg::MS_W'(frame_inc) * MS_K;
    fps_ms    = afp_pkg::MS_W'(cfg.target_fps) * MS_K;

    hit   = ef >= afp_pkg::PROD_W'(thr_old);
    draw  = hit && (ef <= afp_pkg::PROD_W'(thr_new));
    skip  = hit && !draw;
    close = (ef + afp_pkg::PROD_W'(MS_K)) > afp_pkg::PROD_W'(fps_ms);

    fps_rep = (flast_r >= slast_r) ? flast_r - slast_r : '0;

    wait_s = (skip && wait_r > WAIT_ONE) ? wait_r - 1'b1 : wait_r;
    wait_h = (loop_inc > cfg.busy_high && wait_s < WAIT_MAX) ? wait_s + 1'b1 : wait_s;

    shown_nxt = shown_r;
    if (draw) begin
      shown_nxt.report_loop_peak = peak_r;
      shown_nxt.report_fps       = fps_rep;
      shown_nxt.report_frame     = frame_inc;
      shown_nxt.report_skips     = slast_r;
      shown_nxt.report_wait      = afp_pkg::WAIT_OUT_W'(wait_r);
    end
    shown_nxt.draw_now = 1'b0;
    shown_nxt.wait_ms  = '0;

    loop_nxt   = loop_inc;
    frame_nxt  = hit ? frame_inc : frame_r;
    skip_nxt   = (skip && skip_r != CNT_MAX) ? skip_r + 1'b1 : skip_r;
    wait_nxt   = wait_s;
    wstart_nxt = wstart_r;
    peak_nxt   = peak_r;
    flast_nxt  = flast_r;
    slast_nxt  = slast_r;
    if (close) begin
      peak_nxt   = loop_inc;
      wait_nxt   = (loop_inc < cfg.busy_low && wait_h > WAIT_ONE) ? wait_h - 1'b1 : wait_h;
      flast_nxt  = frame_nxt;
      slast_nxt  = skip_nxt;
      loop_nxt   = '0;
      frame_nxt  = '0;
      skip_nxt   = '0;
      wstart_nxt = now_tb;
    end

    res          = shown_nxt;
    res.draw_now = draw;
    res.wait_ms  = draw ? afp_pkg::WAIT_OUT_W'(wait_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_r   <= '0;
      frame_r  <= '0;
      skip_r   <= '0;
      wait_r   <= WAIT_MAX;
      wstart_r <= '0;
      peak_r   <= '0;
      flast_r  <= '0;
      slast_r  <= '0;
      shown_r  <= '0;
    end else if (step) begin
      loop_r   <= loop_nxt;
      frame_r  <= frame_nxt;
      skip_r   <= skip_nxt;
      wait_r   <= wait_nxt;
      wstart_r <= wstart_nxt;
      peak_r   <= peak_nxt;
      flast_r  <= flast_nxt;
      slast_r  <= slast_nxt;
      shown_r  <= shown_nxt;
    end
  end

endmodule

[rtl/adaptive_frame_pacer.sv]
// Adaptive frame pacer: one pacing decision per loop pass transfer; each pass goes
// through an input register, then a result register around a single decision stage
// built on one 25x8 multiply, three multiplies by the constant 1000 and a few
// compares. Every pass gives exactly one result; a new pass is taken each cycle unless
// the result register is full and stalled. Configuration writes are always ready and registered.
// Depends on afp_pkg, afp_cfg and afp_core.
module adaptive_frame_pacer #(
  parameter int MAX_WAIT  = afp_pkg::MAX_WAIT_DEF,
  parameter int TIME_BITS = afp_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [afp_pkg::TIME_IN_W-1:0]   in_now_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_draw_now,
  output logic [afp_pkg::WAIT_OUT_W-1:0]  out_wait_ms,
  output logic [afp_pkg::LOOP_W-1:0]      out_report_loop_peak,
  output logic [afp_pkg::CNT_W-1:0]       out_report_fps,
  output logic [afp_pkg::CNT_W-1:0]       out_report_frame,
  output logic [afp_pkg::CNT_W-1:0]       out_report_skips,
  output logic [afp_pkg::WAIT_OUT_W-1:0]  out_report_wait,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [afp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [afp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  afp_pkg::afp_cfg_t cfg;
  afp_pkg::afp_res_t res, out_r;
  logic                          in_vld_r, out_vld_r, adv, in_take;
  logic [afp_pkg::TIME_IN_W-1:0] in_now_r;

  assign adv     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_take = in_valid && !in_stall;

  afp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  afp_core #(
    .MAX_WAIT  (MAX_WAIT),
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (adv),
    .now_ms (in_now_r),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_take || (in_vld_r && !adv);
      out_vld_r <= adv || (out_vld_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_now_r <= in_now_ms;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_draw_now         = out_r.draw_now;
  assign out_wait_ms          = out_r.wait_ms;
  assign out_report_loop_peak = out_r.report_loop_peak;
  assign out_report_fps       = out_r.report_fps;
  assign out_report_frame     = out_r.report_frame;
  assign out_report_skips     = out_r.report_skips;
  assign out_report_wait      = out_r.report_wait;

endmodule

[rtl/afp_checker.sv]
// Port-level checks for the adaptive frame pacer, bound to the top level.
// Depends on afp_pkg and adaptive_frame_pacer_defines.svh.
`include "adaptive_frame_pacer_defines.svh"

module afp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_draw_now,
  input logic [afp_pkg::WAIT_OUT_W-1:0] out_wait_ms,
  input logic [afp_pkg::CNT_W-1:0]      out_report_frame,
  input logic [afp_pkg::WAIT_OUT_W-1:0] out_report_wait
);

  `AFP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_wait_ms))
  `AFP_ASSERT_NOW(a_idle_wait, out_valid && !out_draw_now, out_wait_ms == '0)
  `AFP_ASSERT_NOW(a_draw_wait, out_valid && out_draw_now, out_wait_ms == out_report_wait)
  `AFP_ASSERT_NOW(a_draw_frame, out_valid && out_draw_now, out_report_frame != '0)

endmodule

bind adaptive_frame_pacer afp_checker u_afp_checker (.*);
